### rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

### rtl/hfc_pkg.sv
package hfc_pkg;

  localparam int unsigned DataW = 32;

  typedef enum logic {
    CMD_S2H = 1'b0,
    CMD_H2S = 1'b1
  } cmd_t;

  // Decode of the input after stage 1.
  typedef struct packed {
    cmd_t        cmd;
    logic        sign;
    // Single to half.
    logic        s_zero;     // flush to signed zero
    logic        s_inf;      // infinity or overflow
    logic        s_nan;
    logic        s_sub;      // half subnormal path
    logic [4:0]  s_shift;    // 14..24 for subnormals
    logic [4:0]  s_exp;      // biased half exponent for normals
    logic [23:0] s_sig;      // significand with hidden bit
    // Half to single.
    logic        h_zero;
    logic        h_sub;
    logic        h_special;
    logic [4:0]  h_exp;
    logic [9:0]  h_mant;
  } dec_t;

  // Rounding or normalization done after stage 2.
  typedef struct packed {
    cmd_t        cmd;
    logic        sign;
    logic        s_zero;
    logic        s_inf;
    logic        s_nan;
    logic        s_sub;
    logic [4:0]  s_exp;
    logic [10:0] s_kept;     // kept bits, before increment
    logic        s_round_up;
    logic        h_zero;
    logic        h_special;
    logic [7:0]  h_exp;
    logic [9:0]  h_mant;
  } mid_t;

  function automatic logic [3:0] lzc10(input logic [9:0] m);
    logic [3:0] n;
    n = 4'd10;
    for (int i = 0; i < 10; i++) begin
      if (m[i]) n = 4'(9 - i);
    end
    return n;
  endfunction

endpackage

### rtl/hfc_stream_if.sv
interface hfc_stream_if;
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic [hfc_pkg::DataW-1:0]    value;
  modport source (output valid, command, value, input ready);
  modport sink (input valid, command, value, output ready);
endinterface

### rtl/hfc_result_if.sv
interface hfc_result_if;
  logic                         valid;
  logic                         ready;
  logic [hfc_pkg::DataW-1:0]    result;
  modport source (output valid, result, input ready);
  modport sink (input valid, result, output ready);
endinterface

### rtl/half_float_converter_core.sv
// Three-stage pipeline converting IEEE binary32 to binary16 (command 0, round to
// nearest even, result zero-extended) or binary16 to binary32 (command 1). It takes
// one transaction per cycle unless the output stalls; the stages are decode,
// rounding or leading-zero normalization, and packing. The whole pipe advances
// when its output register is empty or being taken, so a stall holds all.
module half_float_converter_core (
  input  logic  clk,
  input  logic  rst,
  hfc_stream_if.sink   in_ch,
  hfc_result_if.source out_ch
);

  logic          advance;
  logic          dec_valid;
  logic          mid_valid;
  hfc_pkg::dec_t dec;
  hfc_pkg::mid_t mid;

  assign advance = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = advance;

  hfc_decode u_decode (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .command(in_ch.command),
    .value(in_ch.value), .advance(advance), .dec_valid(dec_valid), .dec(dec)
  );

  hfc_round u_round (
    .clk(clk), .rst(rst), .dec_valid(dec_valid), .dec(dec), .advance(advance),
    .mid_valid(mid_valid), .mid(mid)
  );

  hfc_pack u_pack (
    .clk(clk), .rst(rst), .mid_valid(mid_valid), .mid(mid), .advance(advance),
    .out_valid(out_ch.valid), .out_result(out_ch.result)
  );

endmodule

### rtl/hfc_decode.sv
`include "assert_macros.svh"
module hfc_decode (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             command,
  input  logic [31:0]      value,
  input  logic             advance,
  output logic             dec_valid,
  output hfc_pkg::dec_t    dec
);

  hfc_pkg::dec_t dec_next;
  logic [7:0] efield;
  logic [22:0] mant;
  logic [8:0] e;   // efield - 112, two's complement over nine bits

  always_comb begin
    efield = value[30:23];
    mant = value[22:0];
    e = {1'b0, efield} - 9'd112;
    dec_next = '0;
    dec_next.cmd = hfc_pkg::cmd_t'(command);
    if (command == hfc_pkg::CMD_S2H) begin
      dec_next.sign = value[31];
      dec_next.s_sig = {1'b1, mant};
      dec_next.s_exp = e[4:0];
      dec_next.s_shift = 5'(9'd14 - e);
      dec_next.s_nan = (efield == 8'hFF) && (mant != '0);
      // e below -10 flushes; e in -10..0 is subnormal; e of 31 or more overflows.
      dec_next.s_zero = e[8] && (e < 9'h1F6);
      dec_next.s_sub = e[8] ? !(e < 9'h1F6) : (e == 9'd0);
      dec_next.s_inf = !e[8] && (e >= 9'd31);
    end else begin
      dec_next.sign = value[15];
      dec_next.h_exp = value[14:10];
      dec_next.h_mant = value[9:0];
      dec_next.h_zero = (value[14:10] == '0) && (value[9:0] == '0);
      dec_next.h_sub = (value[14:10] == '0) && (value[9:0] != '0);
      dec_next.h_special = (value[14:10] == 5'h1F);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_valid <= 1'b0;
    end else if (advance) begin
      dec_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      dec <= dec_next;
    end
  end

  `ASSERT_IMPL(a_s2h_class_onehot, clk, rst,
    (dec_valid && dec.cmd == hfc_pkg::CMD_S2H) |-> $onehot0({dec.s_zero, dec.s_sub, dec.s_inf}))
  `ASSERT_IMPL(a_nan_is_inf, clk, rst, (dec_valid && dec.s_nan) |-> dec.s_inf)
  `ASSERT_IMPL(a_h2s_class, clk, rst,
    (dec_valid && dec.cmd == hfc_pkg::CMD_H2S) |-> $onehot0({dec.h_zero, dec.h_sub, dec.h_special}))

endmodule

### rtl/hfc_round.sv
`include "assert_macros.svh"
module hfc_round (
  input  logic             clk,
  input  logic             rst,
  input  logic             dec_valid,
  input  hfc_pkg::dec_t    dec,
  input  logic             advance,
  output logic             mid_valid,
  output hfc_pkg::mid_t    mid
);

  hfc_pkg::mid_t mid_next;
  logic [23:0] sh_kept;
  logic [23:0] rem_mask;
  logic [23:0] rem;
  logic [23:0] half;
  logic [3:0]  lz;
  logic [10:0] norm;

  always_comb begin
    mid_next = '0;
    mid_next.cmd = dec.cmd;
    mid_next.sign = dec.sign;
    mid_next.s_zero = dec.s_zero;
    mid_next.s_inf = dec.s_inf;
    mid_next.s_nan = dec.s_nan;
    mid_next.s_sub = dec.s_sub;
    mid_next.s_exp = dec.s_exp;
    mid_next.h_zero = dec.h_zero;
    mid_next.h_special = dec.h_special;
    sh_kept = '0;
    rem_mask = '0;
    rem = '0;
    half = '0;
    lz = '0;
    norm = '0;
    if (dec.s_sub) begin
      sh_kept = dec.s_sig >> dec.s_shift;
      rem_mask = ~(24'hFFFFFF << dec.s_shift);
      rem = dec.s_sig & rem_mask;
      half = 24'd1 << (dec.s_shift - 5'd1);
      mid_next.s_kept = sh_kept[10:0];
      mid_next.s_round_up = (rem > half) || ((rem == half) && sh_kept[0]);
    end else if (dec.s_nan) begin
      mid_next.s_kept = {1'b0, dec.s_sig[22:13] | 10'd1};
    end else begin
      mid_next.s_kept = {1'b0, dec.s_sig[22:13]};
      mid_next.s_round_up = (dec.s_sig[12:0] > 13'h1000) ||
                            ((dec.s_sig[12:0] == 13'h1000) && dec.s_sig[13]);
    end
    // Half to single: exponent and mantissa settled here.
    if (dec.h_sub) begin
      lz = hfc_pkg::lzc10(dec.h_mant);
      norm = {1'b0, dec.h_mant} << (lz + 4'd1);
      mid_next.h_exp = 8'd113 - 8'(lz) - 8'd1;
      mid_next.h_mant = norm[9:0];
    end else if (dec.h_special) begin
      mid_next.h_exp = 8'hFF;
      mid_next.h_mant = dec.h_mant;
    end else begin
      mid_next.h_exp = 8'(dec.h_exp) + 8'd112;
      mid_next.h_mant = dec.h_mant;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (advance) begin
      mid_valid <= dec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      mid <= mid_next;
    end
  end

  `ASSERT_IMPL(a_kept_narrow, clk, rst,
    (mid_valid && mid.s_sub) |-> (mid.s_kept[10] == 1'b0))
  `ASSERT_IMPL(a_hold, clk, rst, (mid_valid && !$past(advance)) |-> $stable(mid))

endmodule

### rtl/hfc_pack.sv
`include "assert_macros.svh"
module hfc_pack (
  input  logic             clk,
  input  logic             rst,
  input  logic             mid_valid,
  input  hfc_pkg::mid_t    mid,
  input  logic             advance,
  output logic             out_valid,
  output logic [31:0]      out_result
);

  logic [31:0] res_next;
  logic [10:0] m_inc;
  logic [5:0]  ex_inc;

  always_comb begin
    m_inc = mid.s_kept + 11'(mid.s_round_up);
    ex_inc = {1'b0, mid.s_exp};
    res_next = '0;
    if (mid.cmd == hfc_pkg::CMD_S2H) begin
      if (mid.s_zero) begin
        res_next = {16'd0, mid.sign, 15'd0};
      end else if (mid.s_nan) begin
        res_next = {16'd0, mid.sign, 5'h1F, mid.s_kept[9:0]};
      end else if (mid.s_inf) begin
        res_next = {16'd0, mid.sign, 15'h7C00};
      end else if (mid.s_sub) begin
        // A carry into bit 10 lands in the exponent field as the smallest normal.
        res_next = {16'd0, mid.sign, 4'd0, m_inc};
      end else begin
        if (m_inc[10]) ex_inc = ex_inc + 6'd1;
        if (ex_inc >= 6'd31) begin
          res_next = {16'd0, mid.sign, 15'h7C00};
        end else begin
          res_next = {16'd0, mid.sign, ex_inc[4:0], m_inc[9:0]};
        end
      end
    end else begin
      if (mid.h_zero) begin
        res_next = {mid.sign, 31'd0};
      end else begin
        res_next = {mid.sign, mid.h_exp, mid.h_mant, 13'd0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= res_next;
    end
  end

  `ASSERT_IMPL(a_out_hold, clk, rst,
    (out_valid && !$past(advance)) |-> $stable(out_result))

endmodule
